### hw/rtl/ges_pkg.sv
// Shared types, constants and helpers of the glyph extent scanner.
`timescale 1ns / 1ps

package ges_pkg;

    // Glyph sheet geometry: a fixed grid of cells, one glyph per cell.
    localparam int unsigned GRID         = 16;
    localparam int unsigned GRID_W       = 4;
    localparam int unsigned NUM_GLYPHS   = 256;
    localparam int unsigned GLYPH_W      = 8;
    localparam int unsigned GLYPH_A      = 65;
    localparam int unsigned MAX_CELL_DEF = 64;

    // Width of the cell size registers and of every per-cell distance.
    localparam int unsigned DIM_W = 7;

    // Width for cell origin sums: grid index times cell size plus a column.
    localparam int unsigned SUM_W = GRID_W + DIM_W + 1;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_WIDTH  = 2'd0,
        CFG_CELL_HEIGHT = 2'd1,
        CFG_KEY_COLOR   = 2'd2
    } cfg_index_t;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Payload widths.
    localparam int unsigned PIXEL_W   = 32;
    localparam int unsigned S_TDATA_W = PIXEL_W + GLYPH_W;
    localparam int unsigned M_TDATA_W = 48;

    // A cell size of zero acts as one; sizes above the maximum are clamped.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_cell);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > int'(max_cell))
        begin
            r = DIM_W'(max_cell);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hw/rtl/ges_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ges_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/glyph_extent_scanner_core.sv
// Top level of the glyph extent scanner: bounding boxes of a bitmap font sheet.
`timescale 1ns / 1ps

// The block scans a 16x16 grid of glyph cells. Each request on the s_ side
// carries a kind in s_tuser: a pixel (raster order, one per request), a read
// of one glyph record, or a clear that starts a new sheet. Only reads produce
// a response on the m_ side; pixels and clears produce none.
//
// A read response passes through the input register, the extent memory read
// and the result register before it appears on m_tvalid. One request is taken
// per cycle while the receiver does not stall. The per-cell column extents
// live in a 256-entry memory; a pixel reads its cell as it enters stage 2
// and writes it back as it leaves stage 2, and a bypass register covers
// back-to-back pixels in the same cell.
//
// Reset clears the pixel counters, the ink flags and the sheet-done flag and
// loads the cell geometry, key color, sheet top and 'A' bottom with defaults.
// No memory sweep is needed: extents of a cell are only used once its ink flag is set.
// Writing cell_width or cell_height through the configuration port clears the
// sheet as a clear request does; configuration must be written only while idle,
// which the block itself does not enforce.
// When the receiver stalls, the whole pipeline holds and s_tready drops in
// the same cycle, so no response is ever lost or duplicated.
module glyph_extent_scanner_core #(
    parameter int unsigned MAX_CELL = ges_pkg::MAX_CELL_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [ges_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ges_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ges_pkg::S_TDATA_W-1:0]    s_tdata,  // pixel_value[31:0], glyph_index[39:32]
    input  logic [1:0]                       s_tuser,  // kind[1:0]
    // Response stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ges_pkg::M_TDATA_W-1:0]    m_tdata   // glyph_left[9:0], glyph_top[19:10],
                                                       // glyph_width[26:20], glyph_height[33:27],
                                                       // space_width[39:34], line_spacing[46:40],
                                                       // sheet_complete[47]
);

    import ges_pkg::*;

    // Width of an in-cell column or row position.
    localparam int unsigned COL_W = (MAX_CELL > 1) ? $clog2(MAX_CELL) : 1;
    // Common width for comparing positions against cell sizes.
    localparam int unsigned EXT_W = COL_W + DIM_W;
    // Sheet top and glyph 'A' bottom after reset: the default cell height as applied.
    localparam logic [DIM_W-1:0] TOP_RESET = eff_dim(DIM_W'(16), MAX_CELL);

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves when the result register is free.
    // ------------------------------------------------------------------
    logic adv;
    logic out_vld_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   cell_width_reg;
    logic [DIM_W-1:0]   cell_height_reg;
    logic [PIXEL_W-1:0] key_color_reg;
    logic [DIM_W-1:0]   cw_eff;
    logic [DIM_W-1:0]   ch_eff;
    logic [DIM_W-1:0]   ch_clear;
    logic               geo_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= DIM_W'(16);
            cell_height_reg <= DIM_W'(16);
            key_color_reg   <= PIXEL_W'(65535);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_CELL_HEIGHT: cell_height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_KEY_COLOR:   key_color_reg   <= cfg_wdata[PIXEL_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cw_eff = eff_dim(cell_width_reg, MAX_CELL);
    assign ch_eff = eff_dim(cell_height_reg, MAX_CELL);

    // A geometry write clears the sheet; the new height is the reset top.
    assign geo_wr = cfg_we && (cfg_index_t'(cfg_index) == CFG_CELL_WIDTH ||
                               cfg_index_t'(cfg_index) == CFG_CELL_HEIGHT);
    assign ch_clear = (cfg_we && cfg_index_t'(cfg_index) == CFG_CELL_HEIGHT)
                    ? eff_dim(cfg_wdata[DIM_W-1:0], MAX_CELL) : ch_eff;

    // ------------------------------------------------------------------
    // Stage 1: input register and raster position counters
    // ------------------------------------------------------------------
    logic               s1_vld_reg;
    kind_t              s1_kind_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [GLYPH_W-1:0] s1_glyph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid)
        begin
            s1_kind_reg  <= kind_t'(s_tuser);
            s1_pixel_reg <= s_tdata[PIXEL_W-1:0];
            s1_glyph_reg <= s_tdata[PIXEL_W +: GLYPH_W];
        end
    end

    // The raster position is kept as cell column / column in cell and
    // cell row / row in cell, so no division is needed per pixel.
    logic [COL_W-1:0]  pcol_reg, pcol_next;
    logic [GRID_W-1:0] ccol_reg, ccol_next;
    logic [COL_W-1:0]  prow_reg, prow_next;
    logic [GRID_W-1:0] crow_reg, crow_next;
    logic              sheet_done_reg, sheet_done_next;
    logic              s1_pix_live;
    logic              pcol_last;
    logic              prow_last;

    assign s1_pix_live = s1_vld_reg && (s1_kind_reg == KIND_PIXEL) && !sheet_done_reg;
    assign pcol_last   = (EXT_W'(pcol_reg) == EXT_W'(cw_eff) - EXT_W'(1));
    assign prow_last   = (EXT_W'(prow_reg) == EXT_W'(ch_eff) - EXT_W'(1));

    always_comb
    begin
        pcol_next       = pcol_reg;
        ccol_next       = ccol_reg;
        prow_next       = prow_reg;
        crow_next       = crow_reg;
        sheet_done_next = sheet_done_reg;
        if (geo_wr)
        begin
            pcol_next       = '0;
            ccol_next       = '0;
            prow_next       = '0;
            crow_next       = '0;
            sheet_done_next = 1'b0;
        end
        else if (adv && s1_vld_reg)
        begin
            case (s1_kind_reg)
                KIND_PIXEL:
                begin
                    if (!sheet_done_reg)
                    begin
                        if (!pcol_last)
                        begin
                            pcol_next = pcol_reg + COL_W'(1);
                        end
                        else
                        begin
                            pcol_next = '0;
                            if (ccol_reg != GRID_W'(GRID - 1))
                            begin
                                ccol_next = ccol_reg + GRID_W'(1);
                            end
                            else
                            begin
                                // End of a raster line: move down one row.
                                ccol_next = '0;
                                if (!prow_last)
                                begin
                                    prow_next = prow_reg + COL_W'(1);
                                end
                                else
                                begin
                                    prow_next = '0;
                                    if (crow_reg != GRID_W'(GRID - 1))
                                    begin
                                        crow_next = crow_reg + GRID_W'(1);
                                    end
                                    else
                                    begin
                                        crow_next       = '0;
                                        sheet_done_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    pcol_next       = '0;
                    ccol_next       = '0;
                    prow_next       = '0;
                    crow_next       = '0;
                    sheet_done_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg       <= '0;
            ccol_reg       <= '0;
            prow_reg       <= '0;
            crow_reg       <= '0;
            sheet_done_reg <= 1'b0;
        end
        else
        begin
            pcol_reg       <= pcol_next;
            ccol_reg       <= ccol_next;
            prow_reg       <= prow_next;
            crow_reg       <= crow_next;
            sheet_done_reg <= sheet_done_next;
        end
    end

    // ------------------------------------------------------------------
    // Extent memory: {last, first} inked column of every cell
    // ------------------------------------------------------------------
    logic [GLYPH_W-1:0]   rd_addr;
    logic [2*COL_W-1:0]   ram_rd_data;
    logic                 wr_en;
    logic [2*COL_W-1:0]   wr_data;

    assign rd_addr = (s1_kind_reg == KIND_READ) ? s1_glyph_reg : {crow_reg, ccol_reg};

    // Stage 2 registers
    logic               s2_vld_reg;
    kind_t              s2_kind_reg;
    logic [GLYPH_W-1:0] s2_g_reg;
    logic               s2_ink_reg;
    logic [COL_W-1:0]   s2_pcol_reg;
    logic [COL_W-1:0]   s2_prow_reg;

    ges_ram #(
        .WIDTH (2 * COL_W),
        .DEPTH (NUM_GLYPHS)
    ) u_extent_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s2_g_reg),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_g_reg    <= rd_addr;
            s2_ink_reg  <= s1_pix_live && (s1_pixel_reg != key_color_reg);
            s2_pcol_reg <= pcol_reg;
            s2_prow_reg <= prow_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: extent update with bypass of the previous write
    // ------------------------------------------------------------------
    logic                  fwd_vld_reg;
    logic [GLYPH_W-1:0]    fwd_g_reg;
    logic [2*COL_W-1:0]    fwd_data_reg;
    logic [2*COL_W-1:0]    cur_ext;
    logic [COL_W-1:0]      cur_first;
    logic [COL_W-1:0]      cur_last;
    logic [COL_W-1:0]      new_first;
    logic [COL_W-1:0]      new_last;
    logic                  cur_has;
    logic                  s2_is_a;

    logic [NUM_GLYPHS-1:0] has_ink_reg, has_ink_next;
    logic [DIM_W-1:0]      global_top_reg, global_top_next;
    logic [DIM_W-1:0]      a_bottom_reg, a_bottom_next;

    // The memory read for this item was issued in the same cycle as the
    // previous item's write, so a write to the same cell is taken from here.
    assign cur_ext   = (fwd_vld_reg && fwd_g_reg == s2_g_reg) ? fwd_data_reg : ram_rd_data;
    assign cur_first = cur_ext[COL_W-1:0];
    assign cur_last  = cur_ext[2*COL_W-1:COL_W];
    assign cur_has   = has_ink_reg[s2_g_reg];
    assign s2_is_a   = (s2_g_reg == GLYPH_W'(GLYPH_A));

    always_comb
    begin
        if (!cur_has)
        begin
            new_first = s2_pcol_reg;
            new_last  = s2_pcol_reg;
        end
        else
        begin
            new_first = (s2_pcol_reg < cur_first) ? s2_pcol_reg : cur_first;
            new_last  = (s2_pcol_reg > cur_last)  ? s2_pcol_reg : cur_last;
        end
    end

    assign wr_en   = adv && s2_vld_reg && (s2_kind_reg == KIND_PIXEL) && s2_ink_reg;
    assign wr_data = {new_last, new_first};

    always_comb
    begin
        has_ink_next    = has_ink_reg;
        global_top_next = global_top_reg;
        a_bottom_next   = a_bottom_reg;
        if (geo_wr)
        begin
            has_ink_next    = '0;
            global_top_next = ch_clear;
            a_bottom_next   = ch_clear;
        end
        else if (adv && s2_vld_reg)
        begin
            case (s2_kind_reg)
                KIND_PIXEL:
                begin
                    if (s2_ink_reg)
                    begin
                        has_ink_next[s2_g_reg] = 1'b1;
                        // Glyph 'A' tracks its lowest inked row for line spacing.
                        if (s2_is_a && (!cur_has ||
                                        EXT_W'(s2_prow_reg) > EXT_W'(a_bottom_reg)))
                        begin
                            a_bottom_next = DIM_W'(s2_prow_reg);
                        end
                        if (EXT_W'(s2_prow_reg) < EXT_W'(global_top_reg))
                        begin
                            global_top_next = DIM_W'(s2_prow_reg);
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    has_ink_next    = '0;
                    global_top_next = ch_eff;
                    a_bottom_next   = ch_eff;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_ink_reg    <= '0;
            global_top_reg <= TOP_RESET;
            a_bottom_reg   <= TOP_RESET;
            fwd_vld_reg    <= 1'b0;
        end
        else
        begin
            has_ink_reg    <= has_ink_next;
            global_top_reg <= global_top_next;
            a_bottom_reg   <= a_bottom_next;
            if (adv)
            begin
                fwd_vld_reg <= wr_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_g_reg    <= s2_g_reg;
            fwd_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Read response: box of one glyph plus sheet-wide metrics
    // ------------------------------------------------------------------
    logic [GRID_W-1:0] rd_ccol;
    logic [GRID_W-1:0] rd_crow;
    logic [SUM_W-1:0]  left_sum;
    logic [SUM_W-1:0]  top_sum;
    logic [COL_W:0]    ink_width;
    logic [9:0]        glyph_left_next;
    logic [9:0]        glyph_top_next;
    logic [6:0]        glyph_width_next;
    logic [6:0]        glyph_height_next;
    logic [5:0]        space_width_next;
    logic [6:0]        line_spacing_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    assign rd_ccol   = s2_g_reg[GRID_W-1:0];
    assign rd_crow   = s2_g_reg[GLYPH_W-1:GRID_W];
    assign left_sum  = SUM_W'(rd_ccol) * SUM_W'(cw_eff)
                     + (cur_has ? SUM_W'(cur_first) : SUM_W'(0));
    assign top_sum   = SUM_W'(rd_crow) * SUM_W'(ch_eff) + SUM_W'(global_top_reg);
    assign ink_width = (COL_W + 1)'(cur_last) - (COL_W + 1)'(cur_first) + (COL_W + 1)'(1);

    assign glyph_left_next   = left_sum[9:0];
    assign glyph_top_next    = top_sum[9:0];
    assign glyph_width_next  = cur_has ? 7'(ink_width) : 7'(cw_eff);
    assign glyph_height_next = 7'(ch_eff - global_top_reg);
    assign space_width_next  = 6'(cw_eff >> 1);
    assign line_spacing_next = 7'(a_bottom_reg - global_top_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= s2_vld_reg && (s2_kind_reg == KIND_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {sheet_done_reg, line_spacing_next, space_width_next,
                             glyph_height_next, glyph_width_next, glyph_top_next,
                             glyph_left_next};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The column counter never reaches the cell width.
    a_pcol_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        EXT_W'(pcol_reg) < EXT_W'(cw_eff))
        else $error("column in cell out of range");

    // The sheet-wide top never lies below the cell height.
    a_top_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        global_top_reg <= ch_eff)
        else $error("global top exceeds cell height");

    // A finished sheet leaves the raster position at the origin.
    a_done_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        sheet_done_reg |-> (pcol_reg == '0 && ccol_reg == '0 &&
                            prow_reg == '0 && crow_reg == '0))
        else $error("raster position not at origin after sheet end");

    // A response only ever follows a read in stage 2.
    a_resp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(s2_vld_reg && s2_kind_reg == KIND_READ))
        else $error("response without a read request");

endmodule
